FILE: hw/rtl/ccbm_pkg.sv
`default_nettype none

package ccbm_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned ALPHABET_SIZE_DEF = 256;
  localparam int unsigned SPAN_BITS_DEF     = 16;

  // Function codes of an input word
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_SPEC  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // Characters with a meaning in the class spec
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic        member;
    logic        all_in_set;
    logic        any_in_set;
    logic [15:0] span_length;
    logic [8:0]  member_count;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_NEGATE,
    ST_FINISH
  } ccbm_state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/ccbm_ram.sv
`default_nettype none

module ccbm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/char_class_builder_matcher.sv
`default_nettype none

// Channel | Direction | Handshake               | Word
// --------+-----------+-------------------------+-------------------------
// in      | input     | in_valid_i / in_ready_o | in_word_i  (in_word_t)
// out     | output    | out_valid_o / out_ready_i | out_word_o (out_word_t)
//
// Query word: one bitmap RAM read, then the result update.
// Spec word: a read-modify-write on the bitmap RAM for each byte added (a
// range x-y with x <= y adds every byte from x to y), plus a negate step when
// the spec negates; the negation itself is a polarity flip, not a sweep.
// Clear word: a sweep of zeros through the whole bitmap; after reset a
// clearing pass runs before the first word is taken.
// A finished result waits in the output register; the next word is taken
// meanwhile and its own result holds back until that register is free.
module char_class_builder_matcher #(
  parameter int unsigned ALPHABET_SIZE = ccbm_pkg::ALPHABET_SIZE_DEF,
  parameter int unsigned SPAN_BITS     = ccbm_pkg::SPAN_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ccbm_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ccbm_pkg::out_word_t      out_word_o
);

  import ccbm_pkg::*;

  localparam int unsigned AW = $clog2(ALPHABET_SIZE);
  localparam int unsigned CW = $clog2(ALPHABET_SIZE + 1);
  localparam logic [8:0]  ALPHA_LIM = 9'(ALPHABET_SIZE);
  localparam logic [AW-1:0] LAST_IDX = AW'(ALPHABET_SIZE - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ALPHABET_SIZE);

  ccbm_state_e state_q, state_d;

  logic [7:0]           addr_q, addr_d;
  logic [7:0]           hi_q, hi_d;
  logic [7:0]           s1_q, s1_d;
  logic                 s1_en_q, s1_en_d;
  logic                 neg_q, neg_d;
  logic                 last_q, last_d;
  logic                 inv_q, inv_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic                 clr_resp_q, clr_resp_d;
  logic [7:0]           pend_byte_q, pend_byte_d;
  logic                 pend_valid_q, pend_valid_d;
  logic                 esc_q, esc_d;
  logic                 rng_q, rng_d;
  logic                 negf_q, negf_d;
  logic                 spec_empty_q, spec_empty_d;
  logic                 spec_start_q, spec_start_d;
  logic                 span_run_q, span_run_d;
  logic [SPAN_BITS-1:0] span_cnt_q, span_cnt_d;
  logic                 any_q, any_d;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q, out_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  logic       out_free;
  logic       in_rng;
  logic       eff_bit;
  logic       q_member;
  logic       q_run;
  logic       q_any;
  logic [SPAN_BITS-1:0] q_span;
  logic [7:0] b;
  logic [7:0] esc_v;
  logic       add0_en;
  logic [7:0] add0_lo;
  logic [7:0] add0_hi;
  logic       end_a_en;
  logic       end_b_en;

  ccbm_ram #(
    .WIDTH (1),
    .DEPTH (ALPHABET_SIZE)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign b           = in_word_i.data_byte;
  assign in_rng      = ({1'b0, addr_q} < ALPHA_LIM);
  assign eff_bit     = ram_rdata ^ inv_q;
  assign ram_raddr   = (state_q == ST_IDLE) ? b[AW-1:0] : addr_q[AW-1:0];
  assign ram_waddr   = (state_q == ST_CLEAR) ? clr_q : addr_q[AW-1:0];

  // Escape translation of a spec byte
  always_comb begin
    case (b)
      CH_LOW_N: esc_v = CH_LF;
      CH_LOW_T: esc_v = CH_TAB;
      CH_LOW_R: esc_v = CH_CR;
      default:  esc_v = b;
    endcase
  end

  // Running query results for the byte at addr_q
  always_comb begin
    q_member = (addr_q != 8'd0) && in_rng && eff_bit;
    q_run    = span_run_q && q_member;
    q_any    = any_q || q_member;
    q_span   = span_cnt_q;
    if (q_member && span_run_q && (span_cnt_q != {SPAN_BITS{1'b1}})) begin
      q_span = span_cnt_q + SPAN_BITS'(1);
    end
  end

  // Sequencer: next state, bitmap access and result loading
  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    hi_d         = hi_q;
    s1_d         = s1_q;
    s1_en_d      = s1_en_q;
    neg_d        = neg_q;
    last_d       = last_q;
    inv_d        = inv_q;
    cnt_d        = cnt_q;
    clr_d        = clr_q;
    clr_resp_d   = clr_resp_q;
    pend_byte_d  = pend_byte_q;
    pend_valid_d = pend_valid_q;
    esc_d        = esc_q;
    rng_d        = rng_q;
    negf_d       = negf_q;
    spec_empty_d = spec_empty_q;
    spec_start_d = spec_start_q;
    span_run_d   = span_run_q;
    span_cnt_d   = span_cnt_q;
    any_d        = any_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ram_we       = 1'b0;
    ram_wdata    = 1'b0;
    add0_en      = 1'b0;
    add0_lo      = 8'd0;
    add0_hi      = 8'd0;
    end_a_en     = 1'b0;
    end_b_en     = 1'b0;

    case (state_q)
      // Sweep zeros through the bitmap
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b0;
        if (clr_q == LAST_IDX) begin
          state_d    = clr_resp_q ? ST_FINISH : ST_IDLE;
          clr_resp_d = 1'b0;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_word_i.func)
            FUNC_CLEAR: begin
              state_d      = ST_CLEAR;
              clr_d        = '0;
              clr_resp_d   = 1'b1;
              inv_d        = 1'b0;
              cnt_d        = '0;
              pend_byte_d  = 8'd0;
              pend_valid_d = 1'b0;
              esc_d        = 1'b0;
              rng_d        = 1'b0;
              negf_d       = 1'b0;
              spec_empty_d = 1'b1;
              spec_start_d = 1'b1;
              span_run_d   = 1'b1;
              span_cnt_d   = '0;
              any_d        = 1'b0;
            end

            FUNC_SPEC: begin
              spec_start_d = 1'b0;
              if (rng_q) begin
                rng_d        = 1'b0;
                pend_valid_d = 1'b0;
                if (pend_byte_q <= b) begin
                  add0_en = 1'b1;
                  add0_lo = pend_byte_q;
                  add0_hi = b;
                end
              end else if (esc_q) begin
                esc_d = 1'b0;
                if (!esc_v[7]) begin
                  add0_en = 1'b1;
                  add0_lo = esc_v;
                  add0_hi = esc_v;
                end
              end else if (spec_start_q && spec_empty_q && (b == CH_CARET)) begin
                negf_d = 1'b1;
              end else if (b == CH_BSLASH) begin
                esc_d = 1'b1;
              end else if ((b == CH_DASH) && pend_valid_q) begin
                rng_d = 1'b1;
              end else begin
                if (pend_valid_q) begin
                  add0_en = 1'b1;
                  add0_lo = pend_byte_q;
                  add0_hi = pend_byte_q;
                end
                pend_byte_d  = b;
                pend_valid_d = 1'b1;
              end

              // Spec end: flush the pending byte, a dangling dash, then negate
              neg_d = 1'b0;
              if (in_word_i.last) begin
                end_a_en     = rng_d || pend_valid_d;
                end_b_en     = rng_d;
                neg_d        = negf_d;
                pend_valid_d = 1'b0;
                rng_d        = 1'b0;
                esc_d        = 1'b0;
                negf_d       = 1'b0;
                spec_start_d = 1'b1;
              end

              s1_d    = CH_DASH;
              s1_en_d = end_b_en;
              if (!add0_en && end_a_en) begin
                add0_en = 1'b1;
                add0_lo = pend_byte_d;
                add0_hi = pend_byte_d;
              end else if (end_a_en) begin
                s1_d    = pend_byte_d;
                s1_en_d = 1'b1;
              end

              addr_d = add0_lo;
              hi_d   = add0_hi;
              if (add0_en) begin
                state_d = ST_ADD_RD;
              end else if (neg_d) begin
                state_d = ST_NEGATE;
              end else begin
                state_d = ST_FINISH;
              end
            end

            FUNC_QUERY: begin
              addr_d  = b;
              last_d  = in_word_i.last;
              state_d = ST_QUERY;
            end

            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      // Update the running query results and hand out the word
      ST_QUERY: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.member       = q_member;
          out_d.all_in_set   = q_run;
          out_d.any_in_set   = q_any;
          out_d.span_length  = 16'(q_span);
          out_d.member_count = 9'(cnt_q);
          if (last_q) begin
            span_run_d = 1'b1;
            span_cnt_d = '0;
            any_d      = 1'b0;
          end else begin
            span_run_d = q_run;
            span_cnt_d = q_span;
            any_d      = q_any;
          end
          state_d = ST_IDLE;
        end
      end

      // Wait for the bitmap read
      ST_ADD_RD: begin
        state_d = ST_ADD_WR;
      end

      // Set the bit if it is clear, then advance along the range
      ST_ADD_WR: begin
        if (in_rng) begin
          spec_empty_d = 1'b0;
          if (!eff_bit) begin
            ram_we    = 1'b1;
            ram_wdata = ~inv_q;
            cnt_d     = cnt_q + CW'(1);
          end
        end
        if (addr_q != hi_q) begin
          addr_d  = addr_q + 8'd1;
          state_d = ST_ADD_RD;
        end else if (s1_en_q) begin
          addr_d  = s1_q;
          hi_d    = s1_q;
          s1_en_d = 1'b0;
          state_d = ST_ADD_RD;
        end else if (neg_q) begin
          state_d = ST_NEGATE;
        end else begin
          state_d = ST_FINISH;
        end
      end

      // Flip the bitmap polarity
      ST_NEGATE: begin
        inv_d   = ~inv_q;
        cnt_d   = FULL_CNT - cnt_q;
        neg_d   = 1'b0;
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.member       = 1'b0;
          out_d.all_in_set   = 1'b0;
          out_d.any_in_set   = 1'b0;
          out_d.span_length  = 16'd0;
          out_d.member_count = 9'(cnt_q);
          state_d            = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      addr_q       <= 8'd0;
      hi_q         <= 8'd0;
      s1_q         <= 8'd0;
      s1_en_q      <= 1'b0;
      neg_q        <= 1'b0;
      last_q       <= 1'b0;
      inv_q        <= 1'b0;
      cnt_q        <= '0;
      clr_q        <= '0;
      clr_resp_q   <= 1'b0;
      pend_byte_q  <= 8'd0;
      pend_valid_q <= 1'b0;
      esc_q        <= 1'b0;
      rng_q        <= 1'b0;
      negf_q       <= 1'b0;
      spec_empty_q <= 1'b1;
      spec_start_q <= 1'b1;
      span_run_q   <= 1'b1;
      span_cnt_q   <= '0;
      any_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      hi_q         <= hi_d;
      s1_q         <= s1_d;
      s1_en_q      <= s1_en_d;
      neg_q        <= neg_d;
      last_q       <= last_d;
      inv_q        <= inv_d;
      cnt_q        <= cnt_d;
      clr_q        <= clr_d;
      clr_resp_q   <= clr_resp_d;
      pend_byte_q  <= pend_byte_d;
      pend_valid_q <= pend_valid_d;
      esc_q        <= esc_d;
      rng_q        <= rng_d;
      negf_q       <= negf_d;
      spec_empty_q <= spec_empty_d;
      spec_start_q <= spec_start_d;
      span_run_q   <= span_run_d;
      span_cnt_q   <= span_cnt_d;
      any_q        <= any_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ccbm_checker.sv
`default_nettype none

module ccbm_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire ccbm_pkg::out_word_t out_word_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // One word at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a word was taken");

  // A member byte means the string has a member
  a_member_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.member |-> out_word_o.any_in_set)
    else $error("member without any_in_set");

  // All-in-set can only hold while the current byte is a member
  a_all_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.all_in_set |-> out_word_o.member)
    else $error("all_in_set without member");

  // A nonzero span needs a member somewhere in the string
  a_span_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.span_length != 16'd0) |-> out_word_o.any_in_set)
    else $error("span without any_in_set");

endmodule

bind char_class_builder_matcher ccbm_checker u_ccbm_checker (.*);

`default_nettype wire
